/* rtl/run_length_encoder_macros.svh */
// ---------------------------------------------------------------------------
// Run-length encoder assertion macros
// Shared concurrent assertion forms used by the encoder top level.
// ---------------------------------------------------------------------------
`ifndef RUN_LENGTH_ENCODER_MACROS_SVH
`define RUN_LENGTH_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLE_ASSERT_IMPLY(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("rle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RLE_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("rle assertion failed");

`endif

/* rtl/rle_pkg.sv */
// ---------------------------------------------------------------------------
// Run-length encoder package
// Widths, constants and the command and result types shared by the encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int PORT_WIDTH  = 16;
	localparam int CMD_DEPTH   = 4;
	localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	localparam count_t COUNT_ONE = count_t'(1);
	localparam count_t COUNT_MAX = '1;

	typedef struct packed {
		value_t value;
		count_t count;
		logic   last;
	} pair_t;

	// One command per accepted item that emits a pair: the run it closed and the final flush.
	typedef struct packed {
		logic  prev_vld;
		pair_t prev;
		logic  fin_vld;
		pair_t fin;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/run_length_encoder.sv */
// ---------------------------------------------------------------------------
// Run-length encoder
// Streams values in and (value, length) run pairs out, list by list.
// ---------------------------------------------------------------------------
// Input queue side: drive sample_value and end_of_list with push; an item
// transfers on a clock edge with push high and full low.
// Output queue side: while empty is low, the oldest pair sits on run_value,
// run_length and last_run; it transfers on an edge with pop high.
// With nothing waiting ahead of it, a pair caused by an item is written into the
// command queue on the item's transfer and then loaded into the output register.
// Items that only lengthen a run emit nothing.
// Throughput: one item per cycle while items emit at most one pair each and the
// receiver keeps popping; an item that closes a run and ends the list emits two
// pairs, which the output register takes one after the other. The four-entry
// command queue absorbs such bursts; full rises only when it fills.
// A run that reaches the largest count is emitted and a new run opened.
// When the receiver stalls, the output pair holds, the queue fills and full
// rises; the open run is kept across the stall.
// Reset clears the open run, the queue and the output valid flag; empty is high
// and full is low after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "run_length_encoder_macros.svh"

module run_length_encoder
	import rle_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [PORT_WIDTH-1:0] sample_value,
	input  wire logic                  end_of_list,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [PORT_WIDTH-1:0]      run_value,
	output logic [PORT_WIDTH-1:0]      run_length,
	output logic                       last_run
);

	logic cmd_push;
	cmd_t cmd_wr;
	logic cmd_full;
	logic cmd_pop;
	cmd_t cmd_rd;
	logic cmd_empty;

	assign full = cmd_full;

	rle_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.sample_value (sample_value),
		.end_of_list  (end_of_list),
		.cmd_full     (cmd_full),
		.cmd_push     (cmd_push),
		.cmd_data     (cmd_wr)
	);

	rle_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	rle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_data   (cmd_rd),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.pop        (pop),
		.empty      (empty),
		.run_value  (run_value),
		.run_length (run_length),
		.last_run   (last_run)
	);

	`RLE_ASSERT_IMPLY(a_no_write_when_full, clk, arst_n, cmd_push, !cmd_full)
	`RLE_ASSERT_IMPLY(a_no_read_when_empty, clk, arst_n, cmd_pop, !cmd_empty)
	`RLE_ASSERT_IMPLY(a_length_nonzero, clk, arst_n, !empty, run_length != '0)
	`RLE_ASSERT_NEXT(a_cmd_drains, clk, arst_n, !cmd_empty && empty, !empty)

endmodule

`default_nettype wire

/* rtl/rle_front.sv */
// ---------------------------------------------------------------------------
// Run-length encoder front end
// Holds the open run, classifies each item and queues the pairs it emits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_front
	import rle_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic [PORT_WIDTH-1:0] sample_value,
	input  wire logic                  end_of_list,
	input  wire logic                  cmd_full,
	output logic                       cmd_push,
	output cmd_t                       cmd_data
);

	value_t cur_value_q;
	count_t cur_count_q;
	logic   run_open_q;

	value_t in_value;
	logic   accept;
	logic   extend;
	value_t nxt_value;
	count_t nxt_count;

	assign in_value = value_t'(sample_value);
	assign accept   = push && !cmd_full;
	assign extend   = run_open_q && (in_value == cur_value_q) && (cur_count_q != COUNT_MAX);

	always_comb begin
		if (extend) begin
			nxt_value = cur_value_q;
			nxt_count = cur_count_q + COUNT_ONE;
		end else begin
			nxt_value = in_value;
			nxt_count = COUNT_ONE;
		end
		cmd_data.prev_vld   = run_open_q && !extend;
		cmd_data.prev.value = cur_value_q;
		cmd_data.prev.count = cur_count_q;
		cmd_data.prev.last  = 1'b0;
		cmd_data.fin_vld    = end_of_list;
		cmd_data.fin.value  = nxt_value;
		cmd_data.fin.count  = nxt_count;
		cmd_data.fin.last   = 1'b1;
	end

	// queue only items that emit something
	assign cmd_push = accept && (cmd_data.prev_vld || cmd_data.fin_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_value_q <= '0;
			cur_count_q <= '0;
			run_open_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_list) begin
				cur_value_q <= '0;
				cur_count_q <= '0;
				run_open_q  <= 1'b0;
			end else begin
				cur_value_q <= nxt_value;
				cur_count_q <= nxt_count;
				run_open_q  <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/rle_cmd_fifo.sv */
// ---------------------------------------------------------------------------
// Run-length encoder command queue
// Short queue of commands between the front end and the emitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_cmd_fifo
	import rle_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output cmd_t      rd_data,
	output logic      empty
);

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0]   fill_q;

	assign full    = (fill_q == (CMD_PTR_W+1)'(CMD_DEPTH));
	assign empty   = (fill_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/rle_back.sv */
// ---------------------------------------------------------------------------
// Run-length encoder emitter
// Splits queued commands into pairs and holds one pair in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_back
	import rle_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cmd_t                   cmd_data,
	input  wire logic                   cmd_empty,
	output logic                        cmd_pop,
	input  wire logic                   pop,
	output logic                        empty,
	output logic [PORT_WIDTH-1:0]       run_value,
	output logic [PORT_WIDTH-1:0]       run_length,
	output logic                        last_run
);

	logic  out_vld_q;
	pair_t out_q;
	logic  half_q;

	logic  load;
	logic  send_prev;

	assign load      = !cmd_empty && (!out_vld_q || pop);
	assign send_prev = cmd_data.prev_vld && !half_q;
	// hold the command while its flush pair is still to go
	assign cmd_pop   = load && !(send_prev && cmd_data.fin_vld);

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= send_prev ? cmd_data.prev : cmd_data.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			half_q    <= 1'b0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
				half_q    <= send_prev && cmd_data.fin_vld;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign empty      = !out_vld_q;
	assign run_value  = PORT_WIDTH'(out_q.value);
	assign run_length = PORT_WIDTH'(out_q.count);
	assign last_run   = out_q.last;

endmodule

`default_nettype wire
